[hdl/dwo_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dwo_pkg
// Shared types and constants of the debounced wheel odometer.
// ----------------------------------------------------------------------------
package dwo_pkg;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int DEBOUNCE_BITS = 16;
  localparam int TPM_BITS      = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE_MS     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TICKS_PER_METER = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WHEEL_ENABLE    = 2'd2;

  localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 16'd100;
  localparam logic [TPM_BITS-1:0]      TPM_RESET      = 16'd20;

  typedef struct packed {
    logic [DEBOUNCE_BITS-1:0] debounce_ms;
    logic [TPM_BITS-1:0]      ticks_per_meter;
    logic                     wheel_enable;
  } cfg_t;

endpackage : dwo_pkg
`default_nettype wire

[hdl/dwo_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dwo_fifo
// Two-entry queue between the debounce front and the divider back.
// ----------------------------------------------------------------------------
module dwo_fifo #(
  parameter int WIDTH = 26
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en && !full, rd_en && !empty})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule : dwo_fifo
`default_nettype wire

[hdl/dwo_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dwo_front
// Takes tick and clear requests, runs the debounce timer and the pulse count,
// and queues event, latched level and count for the distance divider.
// ----------------------------------------------------------------------------
module dwo_front
  import dwo_pkg::*;
#(
  parameter int COUNT_BITS = 24,
  parameter int TIMER_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cfg_t                    cfg,
  input  wire logic                    push,
  input  wire logic                    full,
  input  wire logic                    cmd,
  input  wire logic                    sensor_level,
  input  wire logic                    fall_edge,
  output logic                         wr_en,
  output logic [COUNT_BITS+1:0]        wr_data
);

  localparam int CMP_BITS = (TIMER_BITS > DEBOUNCE_BITS) ? TIMER_BITS : DEBOUNCE_BITS;

  logic                  low_latched, low_latched_next;
  logic                  timing_active, timing_active_next;
  logic [TIMER_BITS-1:0] elapsed_ms, elapsed_ms_next;
  logic [COUNT_BITS-1:0] count_reg, count_reg_next;
  logic                  event_next;
  logic                  accept;
  logic                  over_debounce;

  assign accept = push && !full;

  always_comb begin
    low_latched_next   = low_latched;
    timing_active_next = timing_active;
    elapsed_ms_next    = elapsed_ms;
    count_reg_next     = count_reg;
    event_next         = 1'b0;
    over_debounce      = 1'b0;
    if (cmd) begin
      count_reg_next = '0;
    end else if (cfg.wheel_enable) begin
      if (fall_edge) begin
        elapsed_ms_next    = '0;
        timing_active_next = 1'b1;
      end else if (timing_active && (elapsed_ms != '1)) begin
        elapsed_ms_next = elapsed_ms + 1'b1;
      end
      over_debounce = CMP_BITS'(elapsed_ms_next) > CMP_BITS'(cfg.debounce_ms);
      if (!low_latched) begin
        if (timing_active_next) begin
          if (sensor_level) begin
            timing_active_next = 1'b0;
            elapsed_ms_next    = '0;
          end else if (over_debounce) begin
            low_latched_next = 1'b1;
            event_next       = 1'b1;
            if (count_reg != '1) begin
              count_reg_next = count_reg + 1'b1;
            end
          end
        end
      end else if (over_debounce && sensor_level) begin
        low_latched_next   = 1'b0;
        timing_active_next = 1'b0;
        elapsed_ms_next    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_latched   <= 1'b0;
      timing_active <= 1'b0;
      elapsed_ms    <= '0;
      count_reg     <= '0;
    end else if (accept) begin
      low_latched   <= low_latched_next;
      timing_active <= timing_active_next;
      elapsed_ms    <= elapsed_ms_next;
      count_reg     <= count_reg_next;
    end
  end

  assign wr_en   = accept;
  assign wr_data = {event_next, low_latched_next, count_reg_next};

endmodule : dwo_front
`default_nettype wire

[hdl/dwo_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dwo_back
// Pulls one queued request, divides count << FRAC_BITS by ticks per meter
// one quotient bit a cycle, and holds the result until it is popped.
// ----------------------------------------------------------------------------
module dwo_back
  import dwo_pkg::*;
#(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire cfg_t                            cfg,
  input  wire logic                            q_empty,
  input  wire logic [COUNT_BITS+1:0]           q_data,
  output logic                                 q_rd,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic                                 tick_event,
  output logic                                 sensor_low,
  output logic [COUNT_BITS-1:0]                pulse_count,
  output logic [COUNT_BITS+FRAC_BITS-1:0]      distance_q16
);

  localparam int DIST_BITS = COUNT_BITS + FRAC_BITS;
  localparam int CNT_BITS  = $clog2(DIST_BITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]           state;
  logic [CNT_BITS-1:0]  steps;
  logic [TPM_BITS-1:0]  rem;
  logic [DIST_BITS-1:0] quo;
  logic [TPM_BITS:0]    shifted;
  logic                 ge;

  // partial remainder stays below the divisor, so 17 bits cover the shift
  assign shifted = {rem, quo[DIST_BITS-1]};
  assign ge      = shifted >= {1'b0, cfg.ticks_per_meter};

  assign q_rd         = (state == ST_IDLE) && !q_empty;
  assign empty        = (state != ST_HOLD);
  assign distance_q16 = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      steps <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_BUSY;
            steps <= CNT_BITS'(DIST_BITS);
          end
        end
        ST_BUSY: begin
          steps <= steps - 1'b1;
          if (steps == CNT_BITS'(1)) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (pop) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && !q_empty) begin
      tick_event  <= q_data[COUNT_BITS+1];
      sensor_low  <= q_data[COUNT_BITS];
      pulse_count <= q_data[COUNT_BITS-1:0];
      quo         <= {q_data[COUNT_BITS-1:0], {FRAC_BITS{1'b0}}};
      rem         <= '0;
    end else if (state == ST_BUSY) begin
      // quotient bits shift in behind the numerator bits
      quo <= {quo[DIST_BITS-2:0], ge};
      rem <= ge ? TPM_BITS'(shifted - {1'b0, cfg.ticks_per_meter})
                : shifted[TPM_BITS-1:0];
    end
  end

endmodule : dwo_back
`default_nettype wire

[hdl/debounced_wheel_odometer_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// debounced_wheel_odometer_core
// Debounced wheel pulse counter with distance in unsigned fixed point.
//
//   channel   handshake              payload
//   --------  ---------------------  -----------------------------------------
//   input     push / full            cmd, sensor_level, fall_edge
//   result    empty / pop            tick_event, sensor_low, pulse_count,
//                                    distance_q16
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front takes a request whenever the queue is not full and runs debounce
// and count at once. The divider back works on one request at a time: it loads
// it, computes one quotient bit per cycle, holds the result, frees after pop.
// A two-entry queue lets the front keep taking requests while a result waits, until full.
// Synchronous reset loads register defaults and clears all control state.
// ----------------------------------------------------------------------------
module debounced_wheel_odometer_core
  import dwo_pkg::*;
#(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16,
  parameter int TIMER_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          cmd,
  input  wire logic                          sensor_level,
  input  wire logic                          fall_edge,
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               tick_event,
  output logic                               sensor_low,
  output logic [COUNT_BITS-1:0]              pulse_count,
  output logic [COUNT_BITS+FRAC_BITS-1:0]    distance_q16,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]      cfg_data
);

  cfg_t                  cfg;
  logic                  q_wr;
  logic [COUNT_BITS+1:0] q_wr_data;
  logic                  q_rd;
  logic [COUNT_BITS+1:0] q_rd_data;
  logic                  q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms     <= DEBOUNCE_RESET;
      cfg.ticks_per_meter <= TPM_RESET;
      cfg.wheel_enable    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE_MS:     cfg.debounce_ms     <= cfg_data;
        REG_TICKS_PER_METER: cfg.ticks_per_meter <= cfg_data;
        REG_WHEEL_ENABLE:    cfg.wheel_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dwo_front #(
    .COUNT_BITS (COUNT_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .sensor_level (sensor_level),
    .fall_edge    (fall_edge),
    .wr_en        (q_wr),
    .wr_data      (q_wr_data)
  );

  dwo_fifo #(
    .WIDTH (COUNT_BITS + 2)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wr_data),
    .full    (full),
    .rd_en   (q_rd),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  dwo_back #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_data       (q_rd_data),
    .q_rd         (q_rd),
    .empty        (empty),
    .pop          (pop),
    .tick_event   (tick_event),
    .sensor_low   (sensor_low),
    .pulse_count  (pulse_count),
    .distance_q16 (distance_q16)
  );

endmodule : debounced_wheel_odometer_core
`default_nettype wire
